>>> hdl/sbd_pkg.sv
// Shared constants, register codes, sequencer step codes and types of the de-esser.
package sbd_pkg;

   localparam int SAMPLE_W     = 24;
   localparam int COEF_W       = 20;
   localparam int BIQUAD_CFG_W = 60;
   localparam int LEVEL_W      = 23;
   localparam int GAIN_W       = 24;
   localparam int RATES_W      = 32;
   localparam int CSR_IDX_W    = 3;
   localparam int CSR_DATA_W   = 60;
   localparam int DEF_CHANNELS = 2;

   localparam logic [GAIN_W-1:0] ONE_Q23 = 24'h800000;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_LOWPASS   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_DETECTOR  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_THRESHOLD = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SATURATE  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_MIN_GAIN  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_KNEE_RCP  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_ENV_RATES = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN_RATES = 3'd7;

   // Sequencer steps: each step consumes the previous product and may issue a new one
   localparam int STEP_W = 5;
   localparam logic [STEP_W-1:0] ST_LP_B0     = 5'd0;
   localparam logic [STEP_W-1:0] ST_DT_B0     = 5'd1;
   localparam logic [STEP_W-1:0] ST_LP_A1     = 5'd2;
   localparam logic [STEP_W-1:0] ST_LP_A2     = 5'd3;
   localparam logic [STEP_W-1:0] ST_DT_A1     = 5'd4;
   localparam logic [STEP_W-1:0] ST_DT_A2     = 5'd5;
   localparam logic [STEP_W-1:0] ST_ENV_MUL   = 5'd6;
   localparam logic [STEP_W-1:0] ST_ENV_UPD   = 5'd7;
   localparam logic [STEP_W-1:0] ST_KNEE_PREP = 5'd8;
   localparam logic [STEP_W-1:0] ST_KNEE_MUL  = 5'd9;
   localparam logic [STEP_W-1:0] ST_T_CLAMP   = 5'd10;
   localparam logic [STEP_W-1:0] ST_T_SQ      = 5'd11;
   localparam logic [STEP_W-1:0] ST_T2        = 5'd12;
   localparam logic [STEP_W-1:0] ST_POLY      = 5'd13;
   localparam logic [STEP_W-1:0] ST_S         = 5'd14;
   localparam logic [STEP_W-1:0] ST_SCALE     = 5'd15;
   localparam logic [STEP_W-1:0] ST_TARGET    = 5'd16;
   localparam logic [STEP_W-1:0] ST_GAIN_PREP = 5'd17;
   localparam logic [STEP_W-1:0] ST_GAIN_MUL  = 5'd18;
   localparam logic [STEP_W-1:0] ST_GAIN_UPD  = 5'd19;
   localparam logic [STEP_W-1:0] ST_OUT_MUL   = 5'd20;
   localparam logic [STEP_W-1:0] ST_FINISH    = 5'd21;

   typedef struct packed {
      logic [BIQUAD_CFG_W-1:0] lowpass_coeffs;
      logic [BIQUAD_CFG_W-1:0] detector_coeffs;
      logic [LEVEL_W-1:0]      threshold_level;
      logic [LEVEL_W-1:0]      saturation_level;
      logic [GAIN_W-1:0]       min_gain;
      logic [GAIN_W-1:0]       knee_reciprocal;
      logic [RATES_W-1:0]      envelope_rates;
      logic [RATES_W-1:0]      gain_rates;
   } cfg_type;

   typedef struct packed {
      logic              load;
      logic              commit;
      logic [STEP_W-1:0] step;
   } cmd_type;

endpackage

>>> hdl/sbd_if.sv
// Request, response and register-write channel interfaces.
interface sbd_req_if import sbd_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic                       channel;
   logic signed [SAMPLE_W-1:0] sample_in;
   modport source (output valid, channel, sample_in, input ready);
   modport sink (input valid, channel, sample_in, output ready);
endinterface

interface sbd_rsp_if import sbd_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic                       channel_out;
   logic signed [SAMPLE_W-1:0] sample_out;
   modport source (output valid, channel_out, sample_out, input ready);
   modport sink (input valid, channel_out, sample_out, output ready);
endinterface

interface sbd_csr_if import sbd_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

>>> hdl/sbd_csr.sv
// Configuration register file of the de-esser.
module sbd_csr import sbd_pkg::*; (
   input  logic   clock,
   input  logic   reset,
   sbd_csr_if.sink csr_chan,
   output cfg_type cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_chan.ready = 1'b1;
   assign cfg = cfg_ff;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_chan.valid) begin
         unique case (csr_chan.index)
            REG_LOWPASS:    cfg_in.lowpass_coeffs   = csr_chan.data;
            REG_DETECTOR:   cfg_in.detector_coeffs  = csr_chan.data;
            REG_THRESHOLD:  cfg_in.threshold_level  = csr_chan.data[LEVEL_W-1:0];
            REG_SATURATE:   cfg_in.saturation_level = csr_chan.data[LEVEL_W-1:0];
            REG_MIN_GAIN:   cfg_in.min_gain         = csr_chan.data[GAIN_W-1:0];
            REG_KNEE_RCP:   cfg_in.knee_reciprocal  = csr_chan.data[GAIN_W-1:0];
            REG_ENV_RATES:  cfg_in.envelope_rates   = csr_chan.data[RATES_W-1:0];
            REG_GAIN_RATES: cfg_in.gain_rates       = csr_chan.data[RATES_W-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.lowpass_coeffs   <= '0;
         cfg_ff.detector_coeffs  <= '0;
         cfg_ff.threshold_level  <= 23'd529290;
         cfg_ff.saturation_level <= 23'd1058580;
         cfg_ff.min_gain         <= 24'd5292898;
         cfg_ff.knee_reciprocal  <= 24'd1038693;
         cfg_ff.envelope_rates   <= 32'd1216414059;
         cfg_ff.gain_rates       <= 32'd1216414214;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

>>> hdl/sbd_ctrl.sv
// Sequencer that steps the shared-multiplier datapath through one sample.
module sbd_ctrl import sbd_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  logic    rsp_ready,
   output logic    rsp_valid,
   output cmd_type cmd
);

   localparam logic S_IDLE = 1'b0;
   localparam logic S_RUN  = 1'b1;

   logic              state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              out_free;
   logic              accept;
   logic              commit;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign commit    = (state_ff == S_RUN) && (step_ff == ST_FINISH) && out_free;
   assign rsp_valid = rsp_valid_ff;

   assign cmd.load   = accept;
   assign cmd.commit = commit;
   assign cmd.step   = step_ff;

   // next state and step
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_RUN;
               step_in  = ST_LP_B0;
            end
         end
         S_RUN: begin
            if (step_ff != ST_FINISH) begin
               step_in = step_ff + 1'b1;
            end else if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // response valid: set on commit, cleared once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      if (commit) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= ST_FINISH;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> hdl/sbd_datapath.sv
// Datapath: per-channel state, one shared 26x26 multiplier and the fix-up arithmetic.
module sbd_datapath import sbd_pkg::*; #(
   parameter int CHANNELS = DEF_CHANNELS
) (
   input  logic                       clock,
   input  logic                       reset,
   input  cmd_type                    cmd,
   input  cfg_type                    cfg,
   input  logic                       channel,
   input  logic signed [SAMPLE_W-1:0] sample_in,
   output logic                       channel_out,
   output logic signed [SAMPLE_W-1:0] sample_out
);

   localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   function automatic logic signed [55:0] rnd(input logic signed [55:0] v,
                                              input int unsigned k);
      rnd = (v + (56'sd1 <<< (k - 1))) >>> k;
   endfunction

   function automatic logic signed [23:0] sat24(input logic signed [55:0] v);
      if (v > 56'sd8388607) sat24 = 24'sh7FFFFF;
      else if (v < -56'sd8388608) sat24 = 24'sh800000;
      else sat24 = v[23:0];
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [55:0] v);
      if (v > 56'sd2147483647) sat32 = 32'sh7FFFFFFF;
      else if (v < -56'sd2147483648) sat32 = 32'sh80000000;
      else sat32 = v[31:0];
   endfunction

   localparam logic [1:0] KNEE_UNITY = 2'd0;
   localparam logic [1:0] KNEE_FLOOR = 2'd1;
   localparam logic [1:0] KNEE_CURVE = 2'd2;

   // per-channel state
   logic signed [31:0]  split_z1_ff [CHANNELS];
   logic signed [31:0]  split_z2_ff [CHANNELS];
   logic signed [31:0]  detect_z1_ff [CHANNELS];
   logic signed [31:0]  detect_z2_ff [CHANNELS];
   logic [GAIN_W-1:0]   envelope_ff [CHANNELS];
   logic [GAIN_W-1:0]   gain_ff [CHANNELS];

   // working registers
   logic                       ch_ff;
   logic signed [SAMPLE_W-1:0] x_ff;
   logic signed [51:0]         p_ff;
   logic signed [43:0]         pl0_ff, pd0_ff;
   logic signed [23:0]         yl_ff, yd_ff;
   logic signed [24:0]         high_ff;
   logic signed [31:0]         nzl1_ff, nzl2_ff, nzd1_ff, nzd2_ff;
   logic signed [24:0]         ediff_ff;
   logic [15:0]                erate_ff;
   logic [GAIN_W-1:0]          envn_ff;
   logic signed [24:0]         kdiff_ff;
   logic signed [24:0]         gm1_ff;
   logic [1:0]                 mode_ff;
   logic [16:0]                t_ff, t2_ff, s_ff;
   logic [17:0]                factor_ff;
   logic [GAIN_W-1:0]          target_ff;
   logic signed [25:0]         gdiff_ff;
   logic [15:0]                grate_ff;
   logic [GAIN_W-1:0]          gainn_ff;
   logic                       ch_out_ff;
   logic signed [SAMPLE_W-1:0] out_ff;

   logic                present;
   logic [CH_W-1:0]     idx;
   logic signed [55:0]  pw;
   logic signed [19:0]  b0l, a1l, a2l, b0d, a1d, a2d;
   logic [GAIN_W-1:0]   env_cur, gain_cur, gmin;
   logic signed [24:0]  rect;
   logic signed [25:0]  mul_a, mul_b;

   logic signed [23:0]  yl_in, yd_in;
   logic signed [24:0]  high_in, ediff_in, kdiff_in, gm1_in;
   logic signed [31:0]  nzl1_in, nzl2_in, nzd1_in, nzd2_in;
   logic [15:0]         erate_in, grate_in;
   logic signed [55:0]  env_sum, tr, t2r, sr, curve_v, gain_sum, out_v;
   logic [GAIN_W-1:0]   envn_in, target_in, gainn_in;
   logic [1:0]          mode_in;
   logic [16:0]         t_in, t2_in, s_in;
   logic [17:0]         factor_in;
   logic signed [25:0]  gdiff_in;
   logic signed [23:0]  out_in;

   assign present = ({31'b0, ch_ff} < 32'(CHANNELS));
   assign idx     = present ? CH_W'(ch_ff) : '0;
   assign pw      = 56'(p_ff);

   assign b0l = cfg.lowpass_coeffs[59:40];
   assign a1l = cfg.lowpass_coeffs[39:20];
   assign a2l = cfg.lowpass_coeffs[19:0];
   assign b0d = cfg.detector_coeffs[59:40];
   assign a1d = cfg.detector_coeffs[39:20];
   assign a2d = cfg.detector_coeffs[19:0];

   assign env_cur  = envelope_ff[idx];
   assign gain_cur = gain_ff[idx];
   assign gmin     = (cfg.min_gain > ONE_Q23) ? ONE_Q23 : cfg.min_gain;

   // biquad fix-ups
   assign yl_in   = sat24(rnd(pw + (56'(split_z1_ff[idx]) <<< 17), 17));
   assign yd_in   = sat24(rnd(pw + (56'(detect_z1_ff[idx]) <<< 17), 17));
   assign high_in = 25'(x_ff) - 25'(yl_ff);
   assign nzl1_in = sat32(rnd((56'(pl0_ff) <<< 1) - pw + (56'(split_z2_ff[idx]) <<< 17), 17));
   assign nzl2_in = sat32(rnd(56'(pl0_ff) - pw, 17));
   assign nzd1_in = sat32(rnd(-(56'(pd0_ff) <<< 1) - pw + (56'(detect_z2_ff[idx]) <<< 17), 17));
   assign nzd2_in = sat32(rnd(56'(pd0_ff) - pw, 17));

   // envelope follower
   assign rect     = yd_ff[23] ? -25'(yd_ff) : 25'(yd_ff);
   assign ediff_in = rect - $signed({1'b0, env_cur});
   assign erate_in = (rect > $signed({1'b0, env_cur})) ? cfg.envelope_rates[31:16]
                                                       : cfg.envelope_rates[15:0];
   assign env_sum  = $signed({32'b0, env_cur}) + rnd(pw, 16);
   assign envn_in  = (env_sum < 56'sd0) ? '0 :
                     (env_sum > 56'sd8388608) ? ONE_Q23 : env_sum[23:0];

   // knee
   assign kdiff_in = $signed({1'b0, envn_ff}) - $signed({2'b0, cfg.threshold_level});
   assign gm1_in   = $signed({1'b0, gmin}) - $signed({1'b0, ONE_Q23});
   always_comb begin
      if (envn_ff <= {1'b0, cfg.threshold_level}) mode_in = KNEE_UNITY;
      else if (cfg.saturation_level <= cfg.threshold_level ||
               envn_ff >= {1'b0, cfg.saturation_level}) mode_in = KNEE_FLOOR;
      else mode_in = KNEE_CURVE;
   end
   assign tr        = rnd(pw, 23);
   assign t_in      = (tr < 56'sd0) ? '0 : (tr > 56'sd65536) ? 17'd65536 : tr[16:0];
   assign t2r       = rnd(pw, 16);
   assign t2_in     = t2r[16:0];
   assign factor_in = 18'd196608 - {t_ff, 1'b0};
   assign sr        = rnd(pw, 16);
   assign s_in      = (sr < 56'sd0) ? '0 : (sr > 56'sd65536) ? 17'd65536 : sr[16:0];
   assign curve_v   = 56'sd8388608 + rnd(pw, 16);
   always_comb begin
      case (mode_ff)
         KNEE_UNITY: target_in = ONE_Q23;
         KNEE_FLOOR: target_in = gmin;
         default:    target_in = curve_v[23:0];
      endcase
   end

   // gain smoother and output
   assign gdiff_in = $signed({2'b0, target_ff}) - $signed({2'b0, gain_cur});
   assign grate_in = (target_ff < gain_cur) ? cfg.gain_rates[31:16] : cfg.gain_rates[15:0];
   assign gain_sum = $signed({32'b0, gain_cur}) + rnd(pw, 16);
   assign gainn_in = (gain_sum < 56'sd0) ? '0 :
                     (gain_sum > 56'sd16777215) ? 24'hFFFFFF : gain_sum[23:0];
   assign out_v    = 56'(yl_ff) + rnd(pw, 23);
   assign out_in   = sat24(out_v);

   // multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.step)
         ST_LP_B0:    begin mul_a = 26'(b0l); mul_b = 26'(x_ff); end
         ST_DT_B0:    begin mul_a = 26'(b0d); mul_b = 26'(x_ff); end
         ST_LP_A1:    begin mul_a = 26'(a1l); mul_b = 26'(yl_ff); end
         ST_LP_A2:    begin mul_a = 26'(a2l); mul_b = 26'(yl_ff); end
         ST_DT_A1:    begin mul_a = 26'(a1d); mul_b = 26'(yd_ff); end
         ST_DT_A2:    begin mul_a = 26'(a2d); mul_b = 26'(yd_ff); end
         ST_ENV_MUL:  begin mul_a = $signed({10'b0, erate_ff}); mul_b = 26'(ediff_ff); end
         ST_KNEE_MUL: begin
            mul_a = 26'(kdiff_ff);
            mul_b = $signed({2'b0, cfg.knee_reciprocal});
         end
         ST_T_SQ:     begin mul_a = $signed({9'b0, t_ff}); mul_b = $signed({9'b0, t_ff}); end
         ST_POLY:     begin mul_a = $signed({9'b0, t2_ff}); mul_b = $signed({8'b0, factor_ff}); end
         ST_SCALE:    begin mul_a = 26'(gm1_ff); mul_b = $signed({9'b0, s_ff}); end
         ST_GAIN_MUL: begin mul_a = $signed({10'b0, grate_ff}); mul_b = gdiff_ff; end
         ST_OUT_MUL:  begin mul_a = 26'(high_ff); mul_b = $signed({2'b0, gainn_ff}); end
         default:     begin mul_a = '0; mul_b = '0; end
      endcase
   end

   // working registers: each step latches what it consumes
   always_ff @(posedge clock) begin
      // output product held through the final step while the output register is busy
      if (cmd.step != ST_FINISH) p_ff <= mul_a * mul_b;
      if (cmd.load) begin
         ch_ff <= channel;
         x_ff  <= sample_in;
      end
      case (cmd.step)
         ST_DT_B0: begin
            pl0_ff <= pw[43:0];
            yl_ff  <= yl_in;
         end
         ST_LP_A1: begin
            pd0_ff  <= pw[43:0];
            yd_ff   <= yd_in;
            high_ff <= high_in;
         end
         ST_LP_A2: nzl1_ff <= nzl1_in;
         ST_DT_A1: begin
            nzl2_ff  <= nzl2_in;
            ediff_ff <= ediff_in;
            erate_ff <= erate_in;
         end
         ST_DT_A2:   nzd1_ff <= nzd1_in;
         ST_ENV_MUL: nzd2_ff <= nzd2_in;
         ST_ENV_UPD: envn_ff <= envn_in;
         ST_KNEE_PREP: begin
            kdiff_ff <= kdiff_in;
            gm1_ff   <= gm1_in;
            mode_ff  <= mode_in;
         end
         ST_T_CLAMP: t_ff <= t_in;
         ST_T2: begin
            t2_ff     <= t2_in;
            factor_ff <= factor_in;
         end
         ST_S:      s_ff <= s_in;
         ST_TARGET: target_ff <= target_in;
         ST_GAIN_PREP: begin
            gdiff_ff <= gdiff_in;
            grate_ff <= grate_in;
         end
         ST_GAIN_UPD: gainn_ff <= gainn_in;
         default: ;
      endcase
      if (cmd.commit) begin
         ch_out_ff <= ch_ff;
         out_ff    <= present ? out_in : x_ff;
      end
   end

   // channel state: written back once a sample completes
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            split_z1_ff[i]  <= '0;
            split_z2_ff[i]  <= '0;
            detect_z1_ff[i] <= '0;
            detect_z2_ff[i] <= '0;
            envelope_ff[i]  <= '0;
            gain_ff[i]      <= ONE_Q23;
         end
      end else if (cmd.commit && present) begin
         split_z1_ff[idx]  <= nzl1_ff;
         split_z2_ff[idx]  <= nzl2_ff;
         detect_z1_ff[idx] <= nzd1_ff;
         detect_z2_ff[idx] <= nzd2_ff;
         envelope_ff[idx]  <= envn_ff;
         gain_ff[idx]      <= gainn_ff;
      end
   end

   assign channel_out = ch_out_ff;
   assign sample_out  = out_ff;

endmodule

>>> hdl/split_band_deesser.sv
// Top level of the split-band de-esser: register file, sequencer and datapath.
//
//   channel    direction  handshake      payload
//   req_chan   in         valid/ready    channel, sample_in
//   rsp_chan   out        valid/ready    channel_out, sample_out
//   csr_chan   in         valid/ready    index, data (ready always high)
//
// For each accepted sample, from acceptance to response, the single shared
// 26x26 multiplier is used thirteen times, with a fix-up step between dependent products.
// A new request is accepted the cycle after the previous response is committed to the
// output register; a response still waiting there does not hold off the next request.
// A finished sample waits in its last step while the output register is still occupied.
// Synchronous active-high reset clears all filter and envelope state; gains go to unity.
module split_band_deesser import sbd_pkg::*; #(
   parameter int CHANNELS = DEF_CHANNELS
) (
   input logic      clock,
   input logic      reset,
   sbd_req_if.sink   req_chan,
   sbd_rsp_if.source rsp_chan,
   sbd_csr_if.sink   csr_chan
);

   cfg_type cfg;
   cmd_type cmd;

   sbd_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .cfg      (cfg)
   );

   sbd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_ready (rsp_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .cmd       (cmd)
   );

   sbd_datapath #(.CHANNELS(CHANNELS)) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .cfg         (cfg),
      .channel     (req_chan.channel),
      .sample_in   (req_chan.sample_in),
      .channel_out (rsp_chan.channel_out),
      .sample_out  (rsp_chan.sample_out)
   );

   // busy once a request is taken
   assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
      else $error("request accepted while a sample is in progress");

   // a response only appears after a commit
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_chan.valid) |-> $past(cmd.commit))
      else $error("response raised without commit");

   // commit only in the final step
   assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (cmd.step == ST_FINISH))
      else $error("commit outside final step");

   // no load while a commit is pending in the same cycle
   assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> !cmd.commit)
      else $error("load and commit together");

endmodule
